@@ sv/dcs_pkg.sv @@
`timescale 1ns / 1ps

package dcs_pkg;

    // default sizes
    localparam int DEF_NUM_TYPES    = 16;
    localparam int DEF_MAX_SLOTS    = 4;
    localparam int DEF_NUM_CLUSTERS = 4;
    localparam int DEF_NUM_REGS     = 64;

    // payload field widths
    localparam int TYPE_W    = 4;
    localparam int REGF_W    = 6;
    localparam int SPACE_W   = 4;
    localparam int READY_W   = 32;
    localparam int SLOT_W    = 2;
    localparam int CLUSTER_W = 2;
    localparam int REMOTE_W  = 2;

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 8;

    // configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    localparam logic [31:0] SLOT_COUNT_RESET = 32'hFFFF_FFFF;
    localparam logic [63:0] SLOT_MAP_RESET   = 64'hE4E4_E4E4_E4E4_E4E4;

    typedef enum logic [1:0] {
        REG_SLOT_COUNT = 2'd0,
        REG_MAP_LOW    = 2'd1,
        REG_MAP_HIGH   = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [31:0] slot_count_minus_one;
        logic [63:0] slot_cluster_map_low;
        logic [63:0] slot_cluster_map_high;
    } cfg_t;

    // producer of one source register
    typedef struct packed {
        logic                 valid;
        logic [CLUSTER_W-1:0] cluster;
    } prod_t;

    typedef struct packed {
        logic                 en;
        logic [CLUSTER_W-1:0] cluster;
    } tbl_wr_t;

    typedef struct packed {
        logic [REMOTE_W-1:0]  remote_sources;
        logic [CLUSTER_W-1:0] chosen_cluster;
        logic [SLOT_W-1:0]    chosen_slot;
    } result_t;

endpackage

@@ sv/dcs_ram.sv @@
`timescale 1ns / 1ps

module dcs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_one,
    input  logic [$clog2(DEPTH)-1:0] raddr_two,
    output logic [WIDTH-1:0]         rdata_one,
    output logic [WIDTH-1:0]         rdata_two
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_one <= mem[raddr_one];
            rdata_two <= mem[raddr_two];
        end
    end

endmodule

@@ sv/dcs_prod_table.sv @@
`timescale 1ns / 1ps

module dcs_prod_table
    import dcs_pkg::*;
#(
    parameter int NUM_REGS = DEF_NUM_REGS
) (
    input  logic                        clk,
    input  logic                        rstn,
    input  logic                        rd_en,
    input  logic [$clog2(NUM_REGS)-1:0] rd_addr_one,
    input  logic [$clog2(NUM_REGS)-1:0] rd_addr_two,
    input  tbl_wr_t                     wr,
    input  logic [$clog2(NUM_REGS)-1:0] wr_addr_one,
    input  logic [$clog2(NUM_REGS)-1:0] wr_addr_two,
    output prod_t                       prod_one,
    output prod_t                       prod_two
);

    localparam int RW = $clog2(NUM_REGS);

    // bank a takes the first destination, bank b the second
    logic                 we_a, we_b;
    logic [CLUSTER_W-1:0] a_one, a_two, b_one, b_two;

    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] last_b_reg;   // set when bank b holds the latest write

    logic [RW-1:0]        addr_one_reg, addr_two_reg;
    logic                 fwd_valid_reg;
    logic [RW-1:0]        fwd_one_reg, fwd_two_reg;
    logic [CLUSTER_W-1:0] fwd_cl_reg;

    assign we_a = wr.en && (wr_addr_one != '0);
    assign we_b = wr.en && (wr_addr_two != '0);

    dcs_ram #(
        .WIDTH (CLUSTER_W),
        .DEPTH (NUM_REGS)
    ) u_bank_a (
        .clk       (clk),
        .we        (we_a),
        .waddr     (wr_addr_one),
        .wdata     (wr.cluster),
        .re        (rd_en),
        .raddr_one (rd_addr_one),
        .raddr_two (rd_addr_two),
        .rdata_one (a_one),
        .rdata_two (a_two)
    );

    dcs_ram #(
        .WIDTH (CLUSTER_W),
        .DEPTH (NUM_REGS)
    ) u_bank_b (
        .clk       (clk),
        .we        (we_b),
        .waddr     (wr_addr_two),
        .wdata     (wr.cluster),
        .re        (rd_en),
        .raddr_one (rd_addr_one),
        .raddr_two (rd_addr_two),
        .rdata_one (b_one),
        .rdata_two (b_two)
    );

    always_ff @(posedge clk) begin
        if (!rstn) begin
            valid_reg     <= '0;
            last_b_reg    <= '0;
            fwd_valid_reg <= 1'b0;
        end else begin
            if (we_a) begin
                valid_reg[wr_addr_one]  <= 1'b1;
                last_b_reg[wr_addr_one] <= 1'b0;
            end
            if (we_b) begin
                valid_reg[wr_addr_two]  <= 1'b1;
                last_b_reg[wr_addr_two] <= 1'b1;
            end
            // a write at the read edge is missed by the ram read, keep it aside
            if (rd_en) begin
                fwd_valid_reg <= wr.en;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            addr_one_reg <= rd_addr_one;
            addr_two_reg <= rd_addr_two;
            fwd_one_reg  <= wr_addr_one;
            fwd_two_reg  <= wr_addr_two;
            fwd_cl_reg   <= wr.cluster;
        end
    end

    logic hit_one, hit_two;

    assign hit_one = fwd_valid_reg && (addr_one_reg != '0) &&
                     ((addr_one_reg == fwd_one_reg) || (addr_one_reg == fwd_two_reg));
    assign hit_two = fwd_valid_reg && (addr_two_reg != '0) &&
                     ((addr_two_reg == fwd_one_reg) || (addr_two_reg == fwd_two_reg));

    always_comb begin
        if (hit_one) begin
            prod_one = '{valid: 1'b1, cluster: fwd_cl_reg};
        end else begin
            prod_one.valid   = valid_reg[addr_one_reg];
            prod_one.cluster = last_b_reg[addr_one_reg] ? b_one : a_one;
        end
        if (hit_two) begin
            prod_two = '{valid: 1'b1, cluster: fwd_cl_reg};
        end else begin
            prod_two.valid   = valid_reg[addr_two_reg];
            prod_two.cluster = last_b_reg[addr_two_reg] ? b_two : a_two;
        end
    end

endmodule

@@ sv/dcs_steer.sv @@
`timescale 1ns / 1ps

module dcs_steer
    import dcs_pkg::*;
#(
    parameter int NUM_TYPES    = DEF_NUM_TYPES,
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
    parameter int NUM_CLUSTERS = DEF_NUM_CLUSTERS
) (
    input  logic               clk,
    input  logic               rstn,
    input  cfg_t               cfg,
    input  logic [TYPE_W-1:0]  instr_type,
    input  logic [SPACE_W-1:0] space,
    input  logic [READY_W-1:0] ready,
    input  prod_t              prod_one,
    input  prod_t              prod_two,
    input  logic               advance,
    output result_t            result
);

    localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int NUM_MAP_SLOTS = 4;

    logic [2:0] rotate_reg [NUM_TYPES];

    logic [TYPE_W-1:0] type_mod [16];
    logic [TYPE_W-1:0] t_full;
    logic [TW-1:0]     t_idx;
    logic [63:0]       map_sel;
    logic [7:0]        type_map;
    logic [1:0]        cnt_raw;
    logic [2:0]        nres_wide, nres;
    logic [2:0]        rs, rs_next;
    logic [SLOT_W-1:0] start;

    logic [CLUSTER_W-1:0] slot_cl  [NUM_MAP_SLOTS];
    logic [REMOTE_W-1:0]  slot_rem [NUM_MAP_SLOTS];

    logic [SLOT_W-1:0]    best;
    logic [CLUSTER_W-1:0] best_cl;
    logic [REMOTE_W-1:0]  best_n;
    logic [2:0]           n_w;
    logic [SLOT_W-1:0]    n;
    logic [7:0]           rb, rn;

    function automatic logic [CLUSTER_W-1:0] cl_mod(input logic [CLUSTER_W-1:0] v);
        if (NUM_CLUSTERS == 1) begin
            return '0;
        end else if ({1'b0, v} >= 3'(NUM_CLUSTERS)) begin
            return v - CLUSTER_W'(NUM_CLUSTERS);
        end else begin
            return v;
        end
    endfunction

    // type reduction worked out at elaboration
    for (genvar g = 0; g < 16; g++) begin : g_type_mod
        assign type_mod[g] = TYPE_W'(g % NUM_TYPES);
    end

    assign t_full   = type_mod[instr_type];
    assign t_idx    = t_full[TW-1:0];
    assign map_sel  = t_full[3] ? cfg.slot_cluster_map_high : cfg.slot_cluster_map_low;
    assign type_map = map_sel[{t_full[2:0], 3'b000} +: 8];
    assign cnt_raw  = cfg.slot_count_minus_one[{t_full, 1'b0} +: 2];
    assign nres_wide = {1'b0, cnt_raw} + 3'd1;
    assign nres      = (nres_wide > 3'(MAX_SLOTS)) ? 3'(MAX_SLOTS) : nres_wide;
    assign rs        = rotate_reg[t_idx];

    always_comb begin
        if (rs >= nres) begin
            start   = '0;
            rs_next = 3'd1;
        end else begin
            start   = rs[SLOT_W-1:0];
            rs_next = rs + 3'd1;
        end
    end

    for (genvar s = 0; s < NUM_MAP_SLOTS; s++) begin : g_slot
        assign slot_cl[s]  = cl_mod(type_map[2*s +: 2]);
        assign slot_rem[s] = REMOTE_W'(prod_one.valid && (prod_one.cluster != slot_cl[s])) +
                             REMOTE_W'(prod_two.valid && (prod_two.cluster != slot_cl[s]));
    end

    // scan in rotation order, ties go to the slot whose cluster has more ready
    always_comb begin
        best    = start;
        best_cl = slot_cl[start];
        best_n  = slot_rem[start];
        n_w     = '0;
        n       = '0;
        rb      = '0;
        rn      = '0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            n_w = {1'b0, start} + 3'(i);
            if (n_w >= nres) begin
                n_w = n_w - nres;
            end
            n  = n_w[SLOT_W-1:0];
            rb = ready[{best_cl, 3'b000} +: 8];
            rn = ready[{slot_cl[n], 3'b000} +: 8];
            if ((3'(i) < nres) && space[slot_cl[n]]) begin
                if ((slot_rem[n] == best_n && rb < rn) || slot_rem[n] < best_n) begin
                    best    = n;
                    best_cl = slot_cl[n];
                    best_n  = slot_rem[n];
                end
            end
        end
    end

    assign result = '{remote_sources: best_n, chosen_cluster: best_cl, chosen_slot: best};

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int k = 0; k < NUM_TYPES; k++) begin
                rotate_reg[k] <= '0;
            end
        end else if (advance) begin
            rotate_reg[t_idx] <= rs_next;
        end
    end

endmodule

@@ sv/dcs_apb_regs.sv @@
`timescale 1ns / 1ps

module dcs_apb_regs
    import dcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rstn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    logic [31:0] slot_count_reg;
    logic [63:0] map_low_reg, map_high_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[4:3];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            slot_count_reg <= SLOT_COUNT_RESET;
            map_low_reg    <= SLOT_MAP_RESET;
            map_high_reg   <= SLOT_MAP_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SLOT_COUNT: slot_count_reg <= pwdata[31:0];
                REG_MAP_LOW:    map_low_reg    <= pwdata;
                REG_MAP_HIGH:   map_high_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SLOT_COUNT: prdata = {32'd0, slot_count_reg};
            REG_MAP_LOW:    prdata = map_low_reg;
            REG_MAP_HIGH:   prdata = map_high_reg;
            default:        prdata = '0;
        endcase
    end

    assign cfg = '{slot_count_minus_one:  slot_count_reg,
                   slot_cluster_map_low:  map_low_reg,
                   slot_cluster_map_high: map_high_reg};

endmodule

@@ sv/dependence_cluster_steering.sv @@
`timescale 1ns / 1ps

// Dependence-based cluster steering: one instruction item per cycle on s_ unless m_tready stalls
// the result register, and one slot choice per item on m_, through an input register, then the
// selection logic into the result register. The producer table is two 64-entry ram banks,
// one per destination, each read at both source registers as the item is accepted, with a
// last-writer bit and a valid bit per register in flops, so it is ready right after reset
// with no clearing pass. Each item's destination writes and rotation update land at the edge
// where it moves to the result register, so the next item already sees them. The result
// register takes a new item whenever it is empty or being drained by m_tready.
module dependence_cluster_steering
    import dcs_pkg::*;
#(
    parameter int NUM_TYPES    = DEF_NUM_TYPES,
    parameter int MAX_SLOTS    = DEF_MAX_SLOTS,
    parameter int NUM_CLUSTERS = DEF_NUM_CLUSTERS,
    parameter int NUM_REGS     = DEF_NUM_REGS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // instr_type[3:0], source_one[9:4], source_two[15:10], dest_one[21:16],
    // dest_two[27:22], cluster_has_space[31:28], cluster_ready_counts[63:32]
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chosen_slot[1:0], chosen_cluster[3:2], remote_sources[5:4], zero[7:6]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int RW = $clog2(NUM_REGS);

    cfg_t    cfg;
    prod_t   prod_one, prod_two;
    tbl_wr_t tbl_wr;
    result_t result;

    logic          accept, advance;
    logic [RW-1:0] rd_one, rd_two, wd_one, wd_two;

    logic               st_valid_reg;
    logic [TYPE_W-1:0]  st_type_reg;
    logic [SPACE_W-1:0] st_space_reg;
    logic [READY_W-1:0] st_ready_reg;
    logic [RW-1:0]      st_d1_reg, st_d2_reg;

    logic    out_valid_reg;
    result_t out_reg;

    // registers past the table read as register zero
    assign rd_one = ({3'b0, s_tdata[9:4]}   < 9'(NUM_REGS)) ? RW'(s_tdata[9:4])   : '0;
    assign rd_two = ({3'b0, s_tdata[15:10]} < 9'(NUM_REGS)) ? RW'(s_tdata[15:10]) : '0;
    assign wd_one = ({3'b0, s_tdata[21:16]} < 9'(NUM_REGS)) ? RW'(s_tdata[21:16]) : '0;
    assign wd_two = ({3'b0, s_tdata[27:22]} < 9'(NUM_REGS)) ? RW'(s_tdata[27:22]) : '0;

    assign advance  = st_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    dcs_apb_regs u_regs (
        .clk     (aclk),
        .rstn    (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dcs_prod_table #(
        .NUM_REGS (NUM_REGS)
    ) u_table (
        .clk         (aclk),
        .rstn        (aresetn),
        .rd_en       (accept),
        .rd_addr_one (rd_one),
        .rd_addr_two (rd_two),
        .wr          (tbl_wr),
        .wr_addr_one (st_d1_reg),
        .wr_addr_two (st_d2_reg),
        .prod_one    (prod_one),
        .prod_two    (prod_two)
    );

    dcs_steer #(
        .NUM_TYPES    (NUM_TYPES),
        .MAX_SLOTS    (MAX_SLOTS),
        .NUM_CLUSTERS (NUM_CLUSTERS)
    ) u_steer (
        .clk        (aclk),
        .rstn       (aresetn),
        .cfg        (cfg),
        .instr_type (st_type_reg),
        .space      (st_space_reg),
        .ready      (st_ready_reg),
        .prod_one   (prod_one),
        .prod_two   (prod_two),
        .advance    (advance),
        .result     (result)
    );

    assign tbl_wr = '{en: advance, cluster: result.chosen_cluster};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_type_reg  <= s_tdata[3:0];
            st_space_reg <= s_tdata[31:28];
            st_ready_reg <= s_tdata[63:32];
            st_d1_reg    <= wd_one;
            st_d2_reg    <= wd_two;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg};

`ifndef SYNTHESIS
    // an item waiting behind a stalled result is kept
    assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && out_valid_reg && !m_tready |=> st_valid_reg)
        else $error("input stage item dropped under stall");

    // with the result register empty the input side is always open
    assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // at most two sources can be remote
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> result.remote_sources != 2'd3)
        else $error("remote source count out of range");

    // chosen cluster lies within the configured cluster count
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> {1'b0, result.chosen_cluster} < 3'(NUM_CLUSTERS))
        else $error("chosen cluster out of range");
`endif

endmodule

@@ tb/tb_dependence_cluster_steering.sv @@
`timescale 1ns / 1ps

module tb_dependence_cluster_steering;
    import dcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_ROWS    = 16;

    // one directed item, with its result typed in where check is set
    typedef struct packed {
        logic [TYPE_W-1:0]    ty;
        logic [REGF_W-1:0]    src1;
        logic [REGF_W-1:0]    src2;
        logic [REGF_W-1:0]    dst1;
        logic [REGF_W-1:0]    dst2;
        logic [SPACE_W-1:0]   space;
        logic [READY_W-1:0]   ready;
        logic                 check;
        logic [SLOT_W-1:0]    exp_slot;
        logic [CLUSTER_W-1:0] exp_cluster;
        logic [REMOTE_W-1:0]  exp_remote;
    } dir_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // mirror of the steering state
    logic [31:0] cfg_slot_count;
    logic [63:0] cfg_map_low;
    logic [63:0] cfg_map_high;
    logic [2:0]  rotation_of [16];
    logic [2:0]  producer_of [64];

    result_t steer_expected [$];
    int      mismatches = 0;
    int      cycle_cnt  = 0;
    int      sink_hold  = 0;
    int      sink_roll;
    logic    sink_open  = 1'b0;
    logic    no_gaps    = 1'b0;
    result_t got_res;
    result_t want_res;

    dir_row_t dir_table [DIR_ROWS] = '{
        // type 0 with plenty of space and flat ready counts keeps slot 0
        '{4'd0,  6'd0,  6'd0,  6'd0,  6'd0,  4'hF,    32'h0000_0000, 1'b1, 2'd0, 2'd0, 2'd0},
        // no space anywhere: rotating start slot is kept
        '{4'd0,  6'd0,  6'd0,  6'd0,  6'd0,  4'h0,    32'hFFFF_FFFF, 1'b1, 2'd1, 2'd1, 2'd0},
        '{4'd0,  6'd0,  6'd0,  6'd0,  6'd0,  4'h0,    32'hFFFF_FFFF, 1'b1, 2'd2, 2'd2, 2'd0},
        '{4'd0,  6'd0,  6'd0,  6'd0,  6'd0,  4'h0,    32'hFFFF_FFFF, 1'b1, 2'd3, 2'd3, 2'd0},
        // rotation wraps back to slot 0
        '{4'd0,  6'd0,  6'd0,  6'd0,  6'd0,  4'h0,    32'hFFFF_FFFF, 1'b1, 2'd0, 2'd0, 2'd0},
        // equal counts, rising ready counts pull the choice along
        '{4'd1,  6'd0,  6'd0,  6'd0,  6'd0,  4'hF,    32'h0403_0201, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd15, 6'd63, 6'd63, 6'd63, 6'd63, 4'hF,    32'hFFFF_FFFF, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd2,  6'd0,  6'd0,  6'd5,  6'd6,  4'b0001, 32'h0000_0000, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd3,  6'd5,  6'd6,  6'd0,  6'd0,  4'b0010, 32'h0000_0000, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd3,  6'd5,  6'd6,  6'd7,  6'd0,  4'hF,    32'h0000_0000, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd4,  6'd5,  6'd6,  6'd8,  6'd9,  4'b1000, 32'h0000_0000, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd5,  6'd8,  6'd5,  6'd0,  6'd0,  4'hF,    32'h1010_1010, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd6,  6'd0,  6'd0,  6'd0,  6'd0,  4'hF,    32'hFF00_00FF, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd7,  6'd63, 6'd0,  6'd0,  6'd63, 4'b0101, 32'h00FF_00FF, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd15, 6'd0,  6'd0,  6'd0,  6'd0,  4'h0,    32'h0000_0000, 1'b0, 2'd0, 2'd0, 2'd0},
        '{4'd9,  6'd1,  6'd2,  6'd0,  6'd0,  4'hF,    32'h0000_0000, 1'b0, 2'd0, 2'd0, 2'd0}
    };

    dependence_cluster_steering i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    function automatic logic [S_DATA_W-1:0] pack_item(
        input logic [3:0] ty, input logic [5:0] s1, input logic [5:0] s2,
        input logic [5:0] d1, input logic [5:0] d2, input logic [3:0] space,
        input logic [31:0] ready);
        return {ready, space, d2, d1, s2, s1, ty};
    endfunction

    function automatic int unsigned cluster_of_slot(input int unsigned ty, input int unsigned slot);
        logic [63:0] map;
        map = (ty < 8) ? cfg_map_low : cfg_map_high;
        return int'(map[(ty % 8) * 8 + slot * 2 +: 2]);
    endfunction

    // sources whose producer sits outside the given cluster
    function automatic int unsigned remote_srcs(input int unsigned cl, input logic [5:0] s1,
                                                input logic [5:0] s2);
        int unsigned n;
        n = 0;
        if (producer_of[s1] != 3'd0 && producer_of[s1] - 3'd1 != 3'(cl)) n++;
        if (producer_of[s2] != 3'd0 && producer_of[s2] - 3'd1 != 3'(cl)) n++;
        return n;
    endfunction

    // picks the slot for one item and updates rotation and producer table
    function automatic result_t steer_predict(input logic [S_DATA_W-1:0] d);
        logic [3:0]  ty;
        logic [5:0]  s1, s2, d1, d2;
        logic [3:0]  space;
        logic [31:0] ready;
        int unsigned nslots, start, best, best_cl, best_n, n, cl, cnt, rb, rn;
        result_t     res;
        ty     = d[3:0];
        s1     = d[9:4];
        s2     = d[15:10];
        d1     = d[21:16];
        d2     = d[27:22];
        space  = d[31:28];
        ready  = d[63:32];
        nslots = int'(cfg_slot_count[2 * ty +: 2]) + 1;
        start  = rotation_of[ty];
        if (start >= nslots) begin
            start = 0;
            rotation_of[ty] = 3'd1;
        end else begin
            rotation_of[ty] = 3'(start + 1);
        end
        best    = start;
        best_cl = cluster_of_slot(ty, start);
        best_n  = remote_srcs(best_cl, s1, s2);
        for (int i = 0; i < nslots; i++) begin
            n = start + i;
            if (n >= nslots) n = n - nslots;
            cl = cluster_of_slot(ty, n);
            if (space[cl]) begin
                cnt = remote_srcs(cl, s1, s2);
                rb  = ready[8 * best_cl +: 8];
                rn  = ready[8 * cl +: 8];
                if ((cnt == best_n && rb < rn) || cnt < best_n) begin
                    best    = n;
                    best_cl = cl;
                    best_n  = cnt;
                end
            end
        end
        if (d1 != 6'd0) producer_of[d1] = 3'(best_cl + 1);
        if (d2 != 6'd0) producer_of[d2] = 3'(best_cl + 1);
        res.chosen_slot    = SLOT_W'(best);
        res.chosen_cluster = CLUSTER_W'(best_cl);
        res.remote_sources = REMOTE_W'(best_n);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [5:0] pick_reg();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 6'($urandom_range(1, 7));
        if (r < 85) return 6'd0;
        return 6'($urandom_range(0, 63));
    endfunction

    function automatic logic [S_DATA_W-1:0] random_item();
        logic [3:0]  space;
        logic [31:0] ready;
        int          r;
        r = $urandom_range(0, 99);
        space = (r < 20) ? 4'hF : (r < 30) ? 4'h0 : 4'($urandom);
        r = $urandom_range(0, 99);
        // repeated bytes make ties on ready counts
        if (r < 30) ready = {4{8'($urandom)}};
        else if (r < 35) ready = 32'h0;
        else if (r < 40) ready = 32'hFFFF_FFFF;
        else ready = $urandom;
        return pack_item(4'($urandom), pick_reg(), pick_reg(), pick_reg(), pick_reg(),
                         space, ready);
    endfunction

    task automatic push_item(input logic [S_DATA_W-1:0] d, input logic use_typed,
                             input result_t typed);
        int      gap;
        result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = steer_predict(d);
        steer_expected.push_back(use_typed ? typed : res);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (steer_expected.size() != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input reg_index_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SLOT_COUNT: cfg_slot_count = value[31:0];
            REG_MAP_LOW:    cfg_map_low    = value;
            REG_MAP_HIGH:   cfg_map_high   = value;
            default: ;
        endcase
    endtask

    task automatic run_phase(input int count);
        no_gaps   = ($urandom_range(0, 3) == 0);
        sink_open <= ($urandom_range(0, 3) == 0);
        repeat (count) push_item(random_item(), 1'b0, '0);
    endtask

    // result side stalls in short and long stretches, or stays open while sink_open is set
    always @(posedge aclk) begin
        if (sink_open) begin
            m_tready <= 1'b1;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 60) begin
                m_tready  <= 1'b1;
                sink_hold <= $urandom_range(0, 7);
            end else if (sink_roll < 92) begin
                m_tready  <= 1'b0;
                sink_hold <= $urandom_range(0, 2);
            end else begin
                m_tready  <= 1'b0;
                sink_hold <= $urandom_range(8, 30);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_res = result_t'(m_tdata[5:0]);
            if (steer_expected.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected item: slot %0d cluster %0d remote %0d",
                             got_res.chosen_slot, got_res.chosen_cluster,
                             got_res.remote_sources);
                mismatches++;
            end else begin
                want_res = steer_expected.pop_front();
                if (got_res.chosen_slot != want_res.chosen_slot
                    || got_res.chosen_cluster != want_res.chosen_cluster
                    || got_res.remote_sources != want_res.remote_sources) begin
                    if (mismatches < 10)
                        $display("mismatch: slot %0d/%0d cluster %0d/%0d remote %0d/%0d",
                                 want_res.chosen_slot, got_res.chosen_slot,
                                 want_res.chosen_cluster, got_res.chosen_cluster,
                                 want_res.remote_sources, got_res.remote_sources);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_dependence_cluster_steering failed");
            $finish;
        end
    end

    initial begin
        cfg_slot_count = SLOT_COUNT_RESET;
        cfg_map_low    = SLOT_MAP_RESET;
        cfg_map_high   = SLOT_MAP_RESET;
        for (int i = 0; i < 16; i++) rotation_of[i] = 3'd0;
        for (int i = 0; i < 64; i++) producer_of[i] = 3'd0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            push_item(pack_item(dir_table[i].ty, dir_table[i].src1, dir_table[i].src2,
                                dir_table[i].dst1, dir_table[i].dst2, dir_table[i].space,
                                dir_table[i].ready),
                      dir_table[i].check,
                      '{remote_sources: dir_table[i].exp_remote,
                        chosen_cluster: dir_table[i].exp_cluster,
                        chosen_slot:    dir_table[i].exp_slot});
        end
        run_phase(100);

        // one slot per type, every slot on cluster 0
        wait_idle();
        cfg_write(REG_SLOT_COUNT, 64'h0);
        cfg_write(REG_MAP_LOW, 64'h0);
        cfg_write(REG_MAP_HIGH, 64'h0);
        run_phase(70);

        // four slots per type, every slot on cluster 3
        wait_idle();
        cfg_write(REG_SLOT_COUNT, 64'hFFFF_FFFF);
        cfg_write(REG_MAP_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_MAP_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        run_phase(70);

        repeat (3) begin
            wait_idle();
            cfg_write(REG_SLOT_COUNT, {32'h0, $urandom});
            cfg_write(REG_MAP_LOW, {$urandom, $urandom});
            cfg_write(REG_MAP_HIGH, {$urandom, $urandom});
            run_phase(80);
        end

        wait_idle();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_dependence_cluster_steering passed");
        end else begin
            $display("tb_dependence_cluster_steering failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/dcs_pkg.sv
sv/dcs_ram.sv
sv/dcs_prod_table.sv
sv/dcs_steer.sv
sv/dcs_apb_regs.sv
sv/dependence_cluster_steering.sv
tb/tb_dependence_cluster_steering.sv
